### rtl/block_ring_buffer_fifo_assert.svh
// Assertion macros for the block ring buffer FIFO.
`ifndef BLOCK_RING_BUFFER_FIFO_ASSERT_SVH
`define BLOCK_RING_BUFFER_FIFO_ASSERT_SVH

`ifndef SYNTHESIS

`define BRF_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("brf assertion failed: same-cycle implication");

`define BRF_ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("brf assertion failed: next-cycle implication");

`else

`define BRF_ASSERT_IMP(name, clk, rst, ante, cons)

`define BRF_ASSERT_NXT(name, clk, rst, ante, cons)

`endif

`endif

### rtl/brf_pkg.sv
// Shared constants, codes and controller/datapath interface types.
`default_nettype none

package brf_pkg;

   localparam int DEPTH       = 1024;
   localparam int MAX_BLOCK   = 64;
   localparam int SAMPLE_BITS = 32;

   localparam int IDX_BITS = $clog2(DEPTH);
   localparam int CNT_BITS = IDX_BITS + 1;
   localparam int REM_BITS = $clog2(MAX_BLOCK + 1);

   localparam int OP_W     = 1;
   localparam int SAMPLE_W = 32;
   localparam int SIZE_W   = 7;
   localparam int KIND_W   = 2;
   localparam int FILL_W   = 10;

   localparam int REQ_TDATA_W = ((SAMPLE_W + SIZE_W + 7) / 8) * 8;
   localparam int RSP_TDATA_W = ((SAMPLE_W + 1 + FILL_W + 7) / 8) * 8;

   localparam logic [OP_W-1:0] OP_PUSH = 1'b0;
   localparam logic [OP_W-1:0] OP_POP  = 1'b1;

   localparam logic [KIND_W-1:0] KIND_STATUS  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_SAMPLE  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_REFUSED = 2'd2;

   typedef struct packed {
      logic push;
      logic pop_start;
      logic pop_refuse;
      logic pop_issue;
   } cmd_type;

   typedef struct packed {
      logic advance;
      logic pop_fits;
      logic pop_last;
   } status_type;

endpackage

`default_nettype wire

### rtl/block_ring_buffer_fifo.sv
// Block ring buffer FIFO: a 1024-word circular sample store that takes pushes
// as whole blocks and serves pops as whole blocks, keeping one slot free. A
// push beat carries one sample; the first beat of a block latches its size and
// drops the whole block if it does not fit, and the last beat commits it and
// returns one status beat. A pop beat returns block_size samples with the last
// one marked, or one refusal beat when too few samples are committed. A push
// beat or a refused pop is taken in one handshake; a served pop holds off the
// input while it issues one read per sample, and its samples stream out one
// per cycle while the output is ready. Every result leaves through a read
// stage and an output register. Back pressure on the result side stalls the
// input. The store needs no clearing after reset.
`default_nettype none

`include "block_ring_buffer_fifo_assert.svh"

module block_ring_buffer_fifo
   import brf_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,  // sample, block_size
   input  wire logic [OP_W-1:0]        req_tuser,  // operation
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0]      rsp_tdata,  // sample_out, accepted, fill_level
   output logic [KIND_W-1:0]           rsp_tuser,  // kind
   output logic                        rsp_tlast
);

   cmd_type             cmd;
   status_type          stat;
   logic [SAMPLE_W-1:0] rsp_sample;
   logic                rsp_accepted;
   logic [FILL_W-1:0]   rsp_fill;

   brf_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_operation (req_tuser),
      .stat          (stat),
      .req_tready    (req_tready),
      .cmd           (cmd)
   );

   brf_dpath u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .req_sample     (req_tdata[SAMPLE_W-1:0]),
      .req_block_size (req_tdata[SAMPLE_W+SIZE_W-1:SAMPLE_W]),
      .rsp_tready     (rsp_tready),
      .stat           (stat),
      .rsp_valid      (rsp_tvalid),
      .rsp_kind       (rsp_tuser),
      .rsp_sample     (rsp_sample),
      .rsp_last       (rsp_tlast),
      .rsp_accepted   (rsp_accepted),
      .rsp_fill       (rsp_fill)
   );

   assign rsp_tdata = RSP_TDATA_W'({rsp_fill, rsp_accepted, rsp_sample});

   `BRF_ASSERT_IMP(a_single_beat_last, clock, reset,
                   rsp_tvalid && (rsp_tuser != KIND_SAMPLE), rsp_tlast)
   `BRF_ASSERT_IMP(a_no_sample_data, clock, reset,
                   rsp_tvalid && (rsp_tuser != KIND_SAMPLE),
                   (rsp_tdata[SAMPLE_W-1:0] == '0)
                   && !(rsp_tuser == KIND_REFUSED && rsp_tdata[SAMPLE_W]))
   `BRF_ASSERT_IMP(a_issue_on_advance, clock, reset, cmd.pop_issue,
                   stat.advance && !req_tready)
   `BRF_ASSERT_NXT(a_pop_blocks_input, clock, reset, cmd.pop_start, !req_tready)

endmodule

`default_nettype wire

### rtl/brf_ctrl.sv
// Controller: input handshake and pop sequencing state machine.
`default_nettype none

module brf_ctrl
   import brf_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_tvalid,
   input  wire logic [OP_W-1:0]  req_operation,
   input  wire status_type       stat,
   output logic                  req_tready,
   output cmd_type               cmd
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_POP  = 1'b1;

   logic state_ff;
   logic state_in;
   logic accept;

   assign req_tready = (state_ff == ST_IDLE) && stat.advance;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      cmd.push       = accept && (req_operation == OP_PUSH);
      cmd.pop_start  = accept && (req_operation == OP_POP) && stat.pop_fits;
      cmd.pop_refuse = accept && (req_operation == OP_POP) && !stat.pop_fits;
      cmd.pop_issue  = (state_ff == ST_POP) && stat.advance;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd.pop_start) begin
               state_in = ST_POP;
            end
         end
         ST_POP: begin
            if (cmd.pop_issue && stat.pop_last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

### rtl/brf_dpath.sv
// Datapath: sample store, ring pointers, block bookkeeping and result pipeline.
`default_nettype none

module brf_dpath
   import brf_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire cmd_type             cmd,
   input  wire logic [SAMPLE_W-1:0] req_sample,
   input  wire logic [SIZE_W-1:0]   req_block_size,
   input  wire logic                rsp_tready,
   output status_type               stat,
   output logic                     rsp_valid,
   output logic [KIND_W-1:0]        rsp_kind,
   output logic [SAMPLE_W-1:0]      rsp_sample,
   output logic                     rsp_last,
   output logic                     rsp_accepted,
   output logic [FILL_W-1:0]        rsp_fill
);

   function automatic logic [REM_BITS-1:0] clamp_size(input logic [SIZE_W-1:0] raw);
      logic [REM_BITS-1:0] n;
      if (raw == '0) begin
         n = REM_BITS'(1);
      end else if (raw > SIZE_W'(MAX_BLOCK)) begin
         n = REM_BITS'(MAX_BLOCK);
      end else begin
         n = REM_BITS'(raw);
      end
      return n;
   endfunction

   function automatic logic [IDX_BITS-1:0] next_slot(input logic [IDX_BITS-1:0] i);
      logic [IDX_BITS-1:0] n;
      if (i == IDX_BITS'(DEPTH - 1)) begin
         n = '0;
      end else begin
         n = i + IDX_BITS'(1);
      end
      return n;
   endfunction

   function automatic logic [CNT_BITS-1:0] used_count(input logic [IDX_BITS-1:0] wr,
                                                     input logic [IDX_BITS-1:0] rd);
      logic [CNT_BITS-1:0] c;
      if (wr >= rd) begin
         c = CNT_BITS'(wr) - CNT_BITS'(rd);
      end else begin
         c = CNT_BITS'(wr) + CNT_BITS'(DEPTH) - CNT_BITS'(rd);
      end
      return c;
   endfunction

   logic [SAMPLE_BITS-1:0] mem [DEPTH];

   logic [IDX_BITS-1:0]    read_ff, read_in;
   logic [IDX_BITS-1:0]    commit_ff, commit_in;
   logic [IDX_BITS-1:0]    stage_ff, stage_in;
   logic [REM_BITS-1:0]    push_rem_ff, push_rem_in;
   logic                   push_drop_ff, push_drop_in;
   logic [REM_BITS-1:0]    pop_rem_ff, pop_rem_in;
   logic [CNT_BITS-1:0]    pop_fill_ff, pop_fill_in;

   logic                   s1_valid_ff, s1_valid_in;
   logic [KIND_W-1:0]      s1_kind_ff, s1_kind_in;
   logic                   s1_last_ff, s1_last_in;
   logic                   s1_acc_ff, s1_acc_in;
   logic [CNT_BITS-1:0]    s1_fill_ff, s1_fill_in;
   logic [SAMPLE_BITS-1:0] rd_data_ff;

   logic                   out_valid_ff, out_valid_in;
   logic [KIND_W-1:0]      out_kind_ff;
   logic [SAMPLE_W-1:0]    out_sample_ff, out_sample_in;
   logic                   out_last_ff;
   logic                   out_acc_ff;
   logic [FILL_W-1:0]      out_fill_ff;

   logic                   advance;
   logic [CNT_BITS-1:0]    used;
   logic [CNT_BITS-1:0]    free;
   logic [REM_BITS-1:0]    blk_n;
   logic                   new_block;
   logic                   drop_eff;
   logic [IDX_BITS-1:0]    stage_eff;
   logic [IDX_BITS-1:0]    stage_nxt;
   logic [REM_BITS-1:0]    rem_eff;
   logic [REM_BITS-1:0]    rem_nxt;
   logic                   block_done;
   logic [IDX_BITS-1:0]    commit_nxt;
   logic [CNT_BITS-1:0]    push_fill;
   logic                   s1_load;

   assign advance = !out_valid_ff || rsp_tready;
   assign used    = used_count(commit_ff, read_ff);
   assign free    = CNT_BITS'(DEPTH - 1) - used;
   assign blk_n   = clamp_size(req_block_size);

   assign new_block  = (push_rem_ff == '0);
   assign drop_eff   = new_block ? (CNT_BITS'(blk_n) > free) : push_drop_ff;
   assign stage_eff  = new_block ? commit_ff : stage_ff;
   assign rem_eff    = new_block ? blk_n : push_rem_ff;
   assign stage_nxt  = next_slot(stage_eff);
   assign rem_nxt    = rem_eff - REM_BITS'(1);
   assign block_done = (rem_nxt == '0);
   assign commit_nxt = drop_eff ? commit_ff : stage_nxt;
   assign push_fill  = used_count(commit_nxt, read_ff);

   always_comb begin
      stat.advance  = advance;
      stat.pop_fits = (CNT_BITS'(blk_n) <= used);
      stat.pop_last = (pop_rem_ff == REM_BITS'(1));
   end

   always_comb begin
      read_in      = read_ff;
      commit_in    = commit_ff;
      stage_in     = stage_ff;
      push_rem_in  = push_rem_ff;
      push_drop_in = push_drop_ff;
      pop_rem_in   = pop_rem_ff;
      pop_fill_in  = pop_fill_ff;
      if (cmd.push) begin
         stage_in     = drop_eff ? stage_eff : stage_nxt;
         push_rem_in  = rem_nxt;
         push_drop_in = block_done ? 1'b0 : drop_eff;
         if (block_done) begin
            commit_in = commit_nxt;
         end
      end
      if (cmd.pop_start) begin
         pop_rem_in  = blk_n;
         pop_fill_in = used - CNT_BITS'(blk_n);
      end
      if (cmd.pop_issue) begin
         read_in    = next_slot(read_ff);
         pop_rem_in = pop_rem_ff - REM_BITS'(1);
      end
   end

   always_comb begin
      s1_load    = 1'b0;
      s1_kind_in = s1_kind_ff;
      s1_last_in = s1_last_ff;
      s1_acc_in  = s1_acc_ff;
      s1_fill_in = s1_fill_ff;
      if (cmd.push && block_done) begin
         s1_load    = 1'b1;
         s1_kind_in = KIND_STATUS;
         s1_last_in = 1'b1;
         s1_acc_in  = !drop_eff;
         s1_fill_in = push_fill;
      end else if (cmd.pop_refuse) begin
         s1_load    = 1'b1;
         s1_kind_in = KIND_REFUSED;
         s1_last_in = 1'b1;
         s1_acc_in  = 1'b0;
         s1_fill_in = used;
      end else if (cmd.pop_issue) begin
         s1_load    = 1'b1;
         s1_kind_in = KIND_SAMPLE;
         s1_last_in = stat.pop_last;
         s1_acc_in  = 1'b0;
         s1_fill_in = pop_fill_ff;
      end
   end

   assign s1_valid_in   = advance ? s1_load : s1_valid_ff;
   assign out_valid_in  = advance ? s1_valid_ff : out_valid_ff;
   assign out_sample_in = (s1_kind_ff == KIND_SAMPLE) ? SAMPLE_W'(rd_data_ff) : '0;

   always_ff @(posedge clock) begin
      if (cmd.push && !drop_eff) begin
         mem[stage_eff] <= SAMPLE_BITS'(req_sample);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.pop_issue) begin
         rd_data_ff <= mem[read_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         read_ff      <= '0;
         commit_ff    <= '0;
         stage_ff     <= '0;
         push_rem_ff  <= '0;
         push_drop_ff <= 1'b0;
         pop_rem_ff   <= '0;
         pop_fill_ff  <= '0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         read_ff      <= read_in;
         commit_ff    <= commit_in;
         stage_ff     <= stage_in;
         push_rem_ff  <= push_rem_in;
         push_drop_ff <= push_drop_in;
         pop_rem_ff   <= pop_rem_in;
         pop_fill_ff  <= pop_fill_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_kind_ff <= s1_kind_in;
         s1_last_ff <= s1_last_in;
         s1_acc_ff  <= s1_acc_in;
         s1_fill_ff <= s1_fill_in;
      end
      if (advance && s1_valid_ff) begin
         out_kind_ff   <= s1_kind_ff;
         out_sample_ff <= out_sample_in;
         out_last_ff   <= s1_last_ff;
         out_acc_ff    <= s1_acc_ff;
         out_fill_ff   <= FILL_W'(s1_fill_ff);
      end
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_kind     = out_kind_ff;
   assign rsp_sample   = out_sample_ff;
   assign rsp_last     = out_last_ff;
   assign rsp_accepted = out_acc_ff;
   assign rsp_fill     = out_fill_ff;

endmodule

`default_nettype wire
